/* sv/ffba_pkg.sv */
// shared constants and types for the first-fit block allocator
// no dependencies
package ffba_pkg;

    localparam int ARENA_BYTES  = 8192;
    localparam int HEADER_BYTES = 6;

    localparam int REQ_W   = 16;
    localparam int OFF_W   = 13;
    localparam int SIZE_W  = 13;
    localparam int NEED_W  = 14;
    localparam int SUM_W   = 15;
    localparam int DEPTH   = ARENA_BYTES / 2;
    localparam int IDX_W   = $clog2(DEPTH);

    // request kinds
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // one block header: used mark and payload size
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    localparam hdr_t RESET_HDR = '{used: 1'b0,
                                   size: SIZE_W'(ARENA_BYTES - HEADER_BYTES)};

endpackage

/* sv/ffba_if.sv */
// request and response channel interfaces of the allocator
// depends on ffba_pkg
interface ffba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [ffba_pkg::REQ_W-1:0]   request_bytes;
    logic [ffba_pkg::OFF_W-1:0]   release_offset;

    modport source (output valid, mode, request_bytes, release_offset, input ready);
    modport sink   (input valid, mode, request_bytes, release_offset, output ready);
endinterface

interface ffba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [ffba_pkg::OFF_W-1:0]   payload_offset;

    modport source (output valid, granted, payload_offset, input ready);
    modport sink   (input valid, granted, payload_offset, output ready);
endinterface

/* sv/first_fit_block_allocator.sv */
// First-fit block allocator over an 8 KiB arena. Block headers (used mark and
// payload size) live in a 4096-entry synchronous memory, one entry per even
// byte address; allocates and non-null releases walk the chain one header per
// cycle. An allocate walks to the first free block large enough, marks it used
// and splits off any remainder big enough for a free block; a release walks to
// the target block, clears its used mark, then walks the whole chain once more
// to merge free runs. Rejected requests and null releases skip the walk. The
// memory read latency sets the one-header-per-cycle pace. A new item is taken
// only when the previous one is finished; a finished result waits in an
// output register while the next item is accepted.
// depends on ffba_pkg and ffba_if
module first_fit_block_allocator (
    input  logic          clk,
    input  logic          rst_n,
    ffba_req_if.sink      req,
    ffba_rsp_if.source    rsp
);

    localparam int OFF_W  = ffba_pkg::OFF_W;
    localparam int SIZE_W = ffba_pkg::SIZE_W;
    localparam int NEED_W = ffba_pkg::NEED_W;
    localparam int SUM_W  = ffba_pkg::SUM_W;
    localparam logic [SUM_W-1:0] HDR_X   = SUM_W'(ffba_pkg::HEADER_BYTES);
    localparam logic [SUM_W-1:0] LIMIT_X = SUM_W'(ffba_pkg::ARENA_BYTES
                                                  - ffba_pkg::HEADER_BYTES);
    localparam logic [SUM_W-1:0] SPLIT_X = SUM_W'(ffba_pkg::HEADER_BYTES + 2);
    localparam logic [16:0]      MAXREQ  = 17'(ffba_pkg::ARENA_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_MISS  = 3'd3;
    localparam logic [2:0] S_MHEAD = 3'd4;
    localparam logic [2:0] S_MRUN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [OFF_W-1:0]   rel_reg, rel_next;
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [OFF_W-1:0]   cur_reg, cur_next;
    logic [OFF_W-1:0]   c_reg, c_next;
    logic [SIZE_W-1:0]  acc_reg, acc_next;
    logic [OFF_W-1:0]   nb_reg, nb_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic               res_ok_reg, res_ok_next;
    logic [OFF_W-1:0]   res_off_reg, res_off_next;
    logic               ovalid_reg, ovalid_next;
    logic               ogrant_reg, ogrant_next;
    logic [OFF_W-1:0]   ooff_reg, ooff_next;
    logic               init0_reg;
    logic               rd0_reg;

    // header memory
    ffba_pkg::hdr_t     mem [ffba_pkg::DEPTH];
    ffba_pkg::hdr_t     mem_q;
    logic               re, we;
    logic [OFF_W-1:0]   ra, wa;
    ffba_pkg::hdr_t     wd;
    ffba_pkg::hdr_t     hdr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa[OFF_W-1:1]] <= wd;
        end
        if (re)
        begin
            mem_q <= mem[ra[OFF_W-1:1]];
        end
    end

    // entry 0 reads as the reset header until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init0_reg <= 1'b1;
            rd0_reg   <= 1'b0;
        end
        else
        begin
            if (we && wa == '0)
            begin
                init0_reg <= 1'b0;
            end
            if (re)
            begin
                rd0_reg <= (ra == '0);
            end
        end
    end

    assign hdr = (rd0_reg && init0_reg) ? ffba_pkg::RESET_HDR : mem_q;

    // address arithmetic on the header just read
    logic [SUM_W-1:0] walk_nxt, run_acc, run_nxt, need_x, size_x;
    logic             walk_on, run_on;

    always_comb
    begin
        size_x   = SUM_W'(hdr.size);
        need_x   = SUM_W'(need_reg);
        walk_nxt = SUM_W'(cur_reg) + HDR_X + size_x;
        walk_on  = (walk_nxt <= LIMIT_X);
        run_acc  = SUM_W'(acc_reg) + HDR_X + size_x;
        run_nxt  = SUM_W'(c_reg) + HDR_X + run_acc;
        run_on   = (run_nxt <= LIMIT_X);
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.granted    = ogrant_reg;
    assign rsp.payload_offset = ooff_reg;

    // request sequencer
    always_comb
    begin
        logic [16:0] req_x;
        state_next   = state_reg;
        mode_next    = mode_reg;
        rel_next     = rel_reg;
        need_next    = need_reg;
        cur_next     = cur_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        nb_next      = nb_reg;
        rem_next     = rem_reg;
        res_ok_next  = res_ok_reg;
        res_off_next = res_off_reg;
        ovalid_next  = ovalid_reg;
        ogrant_next  = ogrant_reg;
        ooff_next    = ooff_reg;
        re           = 1'b0;
        ra           = '0;
        we           = 1'b0;
        wa           = '0;
        wd           = hdr;
        req_x        = 17'(req.request_bytes);

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next    = req.mode;
                    rel_next     = req.release_offset;
                    need_next    = NEED_W'((req_x + 17'd1) & ~17'd1);
                    cur_next     = '0;
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    if (req.mode == ffba_pkg::MODE_ALLOC)
                    begin
                        if (req_x != '0 && req_x <= MAXREQ)
                        begin
                            re         = 1'b1;
                            state_next = S_WALK;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (req.release_offset == '0)
                    begin
                        res_ok_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        re         = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (mode_reg == ffba_pkg::MODE_ALLOC && !hdr.used && size_x >= need_x)
                begin
                    we           = 1'b1;
                    wa           = cur_reg;
                    wd.used      = 1'b1;
                    res_ok_next  = 1'b1;
                    res_off_next = OFF_W'(SUM_W'(cur_reg) + HDR_X);
                    if (size_x >= need_x + SPLIT_X)
                    begin
                        wd.size    = SIZE_W'(need_reg);
                        nb_next    = OFF_W'(SUM_W'(cur_reg) + HDR_X + need_x);
                        rem_next   = SIZE_W'(size_x - need_x - HDR_X);
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (mode_reg == ffba_pkg::MODE_RELEASE
                         && SUM_W'(cur_reg) + HDR_X == SUM_W'(rel_reg))
                begin
                    we         = 1'b1;
                    wa         = cur_reg;
                    wd.used    = 1'b0;
                    cur_next   = '0;
                    state_next = S_MISS;
                end
                else if (walk_on)
                begin
                    re       = 1'b1;
                    ra       = OFF_W'(walk_nxt);
                    cur_next = OFF_W'(walk_nxt);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SPLIT:
            begin
                we         = 1'b1;
                wa         = nb_reg;
                wd.used    = 1'b0;
                wd.size    = rem_reg;
                state_next = S_DONE;
            end

            S_MISS:
            begin
                re          = 1'b1;
                ra          = '0;
                res_ok_next = 1'b1;
                state_next  = S_MHEAD;
            end

            // head of a possible free run
            S_MHEAD:
            begin
                if (!walk_on)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    re       = 1'b1;
                    ra       = OFF_W'(walk_nxt);
                    cur_next = OFF_W'(walk_nxt);
                    if (!hdr.used)
                    begin
                        c_next     = cur_reg;
                        acc_next   = hdr.size;
                        state_next = S_MRUN;
                    end
                end
            end

            // block following a free run head
            S_MRUN:
            begin
                if (!hdr.used)
                begin
                    acc_next = SIZE_W'(run_acc);
                    if (run_on)
                    begin
                        re       = 1'b1;
                        ra       = OFF_W'(run_nxt);
                        cur_next = OFF_W'(run_nxt);
                    end
                    else
                    begin
                        we         = 1'b1;
                        wa         = c_reg;
                        wd.used    = 1'b0;
                        wd.size    = SIZE_W'(run_acc);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    we      = 1'b1;
                    wa      = c_reg;
                    wd.used = 1'b0;
                    wd.size = acc_reg;
                    if (walk_on)
                    begin
                        re         = 1'b1;
                        ra         = OFF_W'(walk_nxt);
                        cur_next   = OFF_W'(walk_nxt);
                        state_next = S_MHEAD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ogrant_next = res_ok_reg;
                    ooff_next   = res_off_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        rel_reg     <= rel_next;
        need_reg    <= need_next;
        cur_reg     <= cur_next;
        c_reg       <= c_next;
        acc_reg     <= acc_next;
        nb_reg      <= nb_next;
        rem_reg     <= rem_next;
        res_ok_reg  <= res_ok_next;
        res_off_reg <= res_off_next;
        ogrant_reg  <= ogrant_next;
        ooff_reg    <= ooff_next;
    end

endmodule

/* sv/ffba_checker.sv */
// port-level checks for the first-fit block allocator
// depends on ffba_pkg; bound to first_fit_block_allocator
module ffba_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       granted,
    input logic [ffba_pkg::OFF_W-1:0] payload_offset
);

    // a waiting result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before taken");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while busy");

    // a failed answer carries no offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !granted |-> payload_offset == '0)
        else $error("offset on failed answer");

    // a granted payload sits past a header on an even address
    a_off_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted && payload_offset != '0
        |-> !payload_offset[0]
            && payload_offset >= ffba_pkg::OFF_W'(ffba_pkg::HEADER_BYTES))
        else $error("granted offset malformed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .granted        (rsp.granted),
    .payload_offset (rsp.payload_offset)
);
